/* rtl/pph_pkg.sv */
// Shared types and constants for the pinhole point projection block.
// Used by the row dot product, the divider cell and the top level.
package pph_pkg;

  // Width of an exact row sum of four 64-bit products.
  localparam int SUM_W = 66;
  // Quotient bits produced by the divider chain, one per cell.
  localparam int QBITS = 33;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_R0_C01    = 3'd0,
    REG_R0_C23    = 3'd1,
    REG_R1_C01    = 3'd2,
    REG_R1_C23    = 3'd3,
    REG_R2_C01    = 3'd4,
    REG_R2_C23    = 3'd5,
    REG_MIN_DEPTH = 3'd6
  } pph_reg_t;

  // Control word that travels beside the data through the divider cells.
  typedef struct packed {
    logic valid;
    logic in_front;
    logic neg_u;
    logic neg_v;
    logic ovf_u;
    logic ovf_v;
  } pph_ctl_t;

endpackage

/* rtl/pph_row_dot.sv */
// One row of the projection matrix times the homogeneous point.
// Two stages: products, then exact sum floored to FRAC_BITS. Uses pph_pkg.
module pph_row_dot
  import pph_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [63:0]             ent_c01,
  input  logic [63:0]             ent_c23,
  input  logic signed [31:0]      px,
  input  logic signed [31:0]      py,
  input  logic signed [31:0]      pz,
  output logic signed [SUM_W-1:0] dot_r
);

  logic signed [63:0] prod0_r, prod1_r, prod2_r, prod3_r;
  logic signed [63:0] prod0_nxt, prod1_nxt, prod2_nxt, prod3_nxt;
  logic signed [31:0] e0, e1, e2, e3;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] dot_nxt;

  assign e0 = signed'(ent_c01[31:0]);
  assign e1 = signed'(ent_c01[63:32]);
  assign e2 = signed'(ent_c23[31:0]);
  assign e3 = signed'(ent_c23[63:32]);

  assign prod0_nxt = 64'(e0) * 64'(px);
  assign prod1_nxt = 64'(e1) * 64'(py);
  assign prod2_nxt = 64'(e2) * 64'(pz);
  // The homogeneous one is a power of two, so the last column is a shift.
  assign prod3_nxt = 64'(e3) <<< FRAC_BITS;

  assign sum = SUM_W'(prod0_r) + SUM_W'(prod1_r) + SUM_W'(prod2_r) + SUM_W'(prod3_r);
  assign dot_nxt = sum >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en) begin
      prod0_r <= prod0_nxt;
      prod1_r <= prod1_nxt;
      prod2_r <= prod2_nxt;
      prod3_r <= prod3_nxt;
      dot_r   <= dot_nxt;
    end
  end

endmodule

/* rtl/pph_div_cell.sv */
// One restoring-division cell: decides quotient bit K for both lanes.
// Cells are chained; each hands remainders and control to the next. Uses pph_pkg.
module pph_div_cell
  import pph_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int K         = 0
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  pph_ctl_t                            ctl_i,
  input  logic [SUM_W-1:0]                    den_i,
  input  logic [SUM_W+FRAC_BITS-1:0]          rem_u_i,
  input  logic [SUM_W+FRAC_BITS-1:0]          rem_v_i,
  input  logic [QBITS-1:0]                    q_u_i,
  input  logic [QBITS-1:0]                    q_v_i,
  output pph_ctl_t                            ctl_r,
  output logic [SUM_W-1:0]                    den_r,
  output logic [SUM_W+FRAC_BITS-1:0]          rem_u_r,
  output logic [SUM_W+FRAC_BITS-1:0]          rem_v_r,
  output logic [QBITS-1:0]                    q_u_r,
  output logic [QBITS-1:0]                    q_v_r
);

  localparam int NW = SUM_W + FRAC_BITS;
  localparam int CW = NW + QBITS;

  logic [CW-1:0] dk, ru, rv;
  logic          den_nz;
  logic          take_u, take_v;
  logic [NW-1:0] rem_u_nxt, rem_v_nxt;
  logic [QBITS-1:0] q_u_nxt, q_v_nxt;

  assign dk = CW'(den_i) << K;
  assign ru = CW'(rem_u_i);
  assign rv = CW'(rem_v_i);
  // A zero divisor takes nothing, so a zero numerator over zero depth gives zero.
  assign den_nz = (den_i != '0);
  assign take_u = den_nz && (ru >= dk);
  assign take_v = den_nz && (rv >= dk);
  assign rem_u_nxt = take_u ? NW'(ru - dk) : rem_u_i;
  assign rem_v_nxt = take_v ? NW'(rv - dk) : rem_v_i;
  assign q_u_nxt = {q_u_i[QBITS-2:0], take_u};
  assign q_v_nxt = {q_v_i[QBITS-2:0], take_v};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r   <= den_i;
      rem_u_r <= rem_u_nxt;
      rem_v_r <= rem_v_nxt;
      q_u_r   <= q_u_nxt;
      q_v_r   <= q_v_nxt;
    end
  end

endmodule

/* rtl/pinhole_point_projection.sv */
// Top level of the pinhole point projection block.
// Depends on pph_pkg, pph_row_dot and pph_div_cell.
//
// Usage: software writes the 3x4 matrix and min_depth through the cfg channel
// (cfg_index selects the register, cfg_data carries the word; cfg_ready is
// always high, unknown indexes are dropped). Points enter on the in channel,
// one word per cycle; each gives exactly one out word with pixel_x, pixel_y,
// in_front and clipped.
// Pipeline: two stages of row dot products, one preparation stage, a chain of
// 33 divider cells (one quotient bit each, both pixel components in the same
// cell) and an output register: 37 register stages. Throughput is one point
// per cycle. The whole pipeline advances when the output register is empty
// or being taken, so in_ready follows out_ready. When the receiver stalls,
// all stages hold and in_ready drops. Synchronous reset clears all valid bits
// and loads the identity matrix [I | 0] and a min_depth of about 0.001.
module pinhole_point_projection
  import pph_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   in_point_x,
  input  logic signed [31:0]   in_point_y,
  input  logic signed [31:0]   in_point_z,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   out_pixel_x,
  output logic signed [31:0]   out_pixel_y,
  output logic                 out_in_front,
  output logic                 out_clipped,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  localparam int NW = SUM_W + FRAC_BITS;
  localparam int CW = NW + QBITS;
  localparam logic [63:0] ONE_LO = 64'(1) << FRAC_BITS;
  localparam logic [63:0] ONE_HI = 64'(1) << (32 + FRAC_BITS);
  localparam int MIN_DEPTH_RST = ((2 ** FRAC_BITS) + 500) / 1000;
  localparam logic [31:0] MINUS_ONE = 32'(0) - (32'(1) << FRAC_BITS);
  localparam logic [QBITS-1:0] LIM_POS = QBITS'(32'h7FFF_FFFF);
  localparam logic [QBITS-1:0] LIM_NEG = QBITS'(32'h8000_0000);

  // Configuration registers.
  logic [63:0] r0_c01_r, r0_c23_r, r1_c01_r, r1_c23_r, r2_c01_r, r2_c23_r;
  logic [30:0] min_depth_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r0_c01_r    <= ONE_LO;
      r0_c23_r    <= '0;
      r1_c01_r    <= ONE_HI;
      r1_c23_r    <= '0;
      r2_c01_r    <= '0;
      r2_c23_r    <= ONE_LO;
      min_depth_r <= 31'(MIN_DEPTH_RST);
    end else if (cfg_valid && cfg_ready) begin
      case (pph_reg_t'(cfg_index))
        REG_R0_C01:    r0_c01_r    <= cfg_data;
        REG_R0_C23:    r0_c23_r    <= cfg_data;
        REG_R1_C01:    r1_c01_r    <= cfg_data;
        REG_R1_C23:    r1_c23_r    <= cfg_data;
        REG_R2_C01:    r2_c01_r    <= cfg_data;
        REG_R2_C23:    r2_c23_r    <= cfg_data;
        REG_MIN_DEPTH: min_depth_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Global advance: every stage moves when the output register can take a word.
  logic adv;
  logic out_valid_r;
  assign adv = !out_valid_r || out_ready;
  assign in_ready = adv;

  logic v1_r, v2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  logic signed [SUM_W-1:0] u_dot, v_dot, w_dot;

  pph_row_dot #(.FRAC_BITS(FRAC_BITS)) u_row0 (
    .clk(clk), .en(adv), .ent_c01(r0_c01_r), .ent_c23(r0_c23_r),
    .px(in_point_x), .py(in_point_y), .pz(in_point_z), .dot_r(u_dot)
  );
  pph_row_dot #(.FRAC_BITS(FRAC_BITS)) u_row1 (
    .clk(clk), .en(adv), .ent_c01(r1_c01_r), .ent_c23(r1_c23_r),
    .px(in_point_x), .py(in_point_y), .pz(in_point_z), .dot_r(v_dot)
  );
  pph_row_dot #(.FRAC_BITS(FRAC_BITS)) u_row2 (
    .clk(clk), .en(adv), .ent_c01(r2_c01_r), .ent_c23(r2_c23_r),
    .px(in_point_x), .py(in_point_y), .pz(in_point_z), .dot_r(w_dot)
  );

  // Preparation stage: depth test, magnitudes and the early overflow check.
  pph_ctl_t          ctl_nxt, ctl3_r;
  logic [SUM_W-1:0]  mag_u, mag_v;
  logic [NW-1:0]     num_u, num_v, num_u3_r, num_v3_r;
  logic [SUM_W-1:0]  den3_r;
  logic [CW-1:0]     den_top;

  assign mag_u = u_dot[SUM_W-1] ? SUM_W'(-u_dot) : SUM_W'(u_dot);
  assign mag_v = v_dot[SUM_W-1] ? SUM_W'(-v_dot) : SUM_W'(v_dot);
  assign num_u = NW'(mag_u) << FRAC_BITS;
  assign num_v = NW'(mag_v) << FRAC_BITS;
  assign den_top = CW'(w_dot) << QBITS;

  always_comb begin
    ctl_nxt.valid    = v2_r;
    ctl_nxt.in_front = !(w_dot < $signed(SUM_W'(min_depth_r)));
    ctl_nxt.neg_u    = u_dot[SUM_W-1];
    ctl_nxt.neg_v    = v_dot[SUM_W-1];
    // A quotient of 2^33 or more saturates whatever its remaining bits are.
    ctl_nxt.ovf_u    = (mag_u != '0) && (CW'(num_u) >= den_top);
    ctl_nxt.ovf_v    = (mag_v != '0) && (CW'(num_v) >= den_top);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl3_r <= '0;
    end else if (adv) begin
      ctl3_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      den3_r   <= w_dot;
      num_u3_r <= num_u;
      num_v3_r <= num_v;
    end
  end

  // Divider chain, most significant quotient bit first.
  pph_ctl_t         ctl_c [QBITS+1];
  logic [SUM_W-1:0] den_c [QBITS+1];
  logic [NW-1:0]    rem_u_c [QBITS+1];
  logic [NW-1:0]    rem_v_c [QBITS+1];
  logic [QBITS-1:0] q_u_c [QBITS+1];
  logic [QBITS-1:0] q_v_c [QBITS+1];

  assign ctl_c[0]   = ctl3_r;
  assign den_c[0]   = den3_r;
  assign rem_u_c[0] = num_u3_r;
  assign rem_v_c[0] = num_v3_r;
  assign q_u_c[0]   = '0;
  assign q_v_c[0]   = '0;

  for (genvar i = 0; i < QBITS; i++) begin : g_cell
    pph_div_cell #(.FRAC_BITS(FRAC_BITS), .K(QBITS - 1 - i)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(adv),
      .ctl_i(ctl_c[i]), .den_i(den_c[i]),
      .rem_u_i(rem_u_c[i]), .rem_v_i(rem_v_c[i]),
      .q_u_i(q_u_c[i]), .q_v_i(q_v_c[i]),
      .ctl_r(ctl_c[i+1]), .den_r(den_c[i+1]),
      .rem_u_r(rem_u_c[i+1]), .rem_v_r(rem_v_c[i+1]),
      .q_u_r(q_u_c[i+1]), .q_v_r(q_v_c[i+1])
    );
  end

  // Saturation and sign, then the output register.
  pph_ctl_t         ctl_l;
  logic [QBITS-1:0] q_u, q_v, lim_u, lim_v, sq_u, sq_v;
  logic             clip_u, clip_v;
  logic [31:0]      px_nxt, py_nxt;
  logic             clip_nxt;

  assign ctl_l  = ctl_c[QBITS];
  assign q_u    = q_u_c[QBITS];
  assign q_v    = q_v_c[QBITS];
  assign lim_u  = ctl_l.neg_u ? LIM_NEG : LIM_POS;
  assign lim_v  = ctl_l.neg_v ? LIM_NEG : LIM_POS;
  assign clip_u = ctl_l.ovf_u || (q_u > lim_u);
  assign clip_v = ctl_l.ovf_v || (q_v > lim_v);
  assign sq_u   = clip_u ? lim_u : q_u;
  assign sq_v   = clip_v ? lim_v : q_v;

  always_comb begin
    if (ctl_l.in_front) begin
      px_nxt   = ctl_l.neg_u ? 32'(-sq_u) : sq_u[31:0];
      py_nxt   = ctl_l.neg_v ? 32'(-sq_v) : sq_v[31:0];
      clip_nxt = clip_u || clip_v;
    end else begin
      px_nxt   = MINUS_ONE;
      py_nxt   = MINUS_ONE;
      clip_nxt = 1'b0;
    end
  end

  logic signed [31:0] px_r, py_r;
  logic               in_front_r, clipped_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ctl_l.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r       <= signed'(px_nxt);
      py_r       <= signed'(py_nxt);
      in_front_r <= ctl_l.in_front;
      clipped_r  <= clip_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_pixel_x  = px_r;
  assign out_pixel_y  = py_r;
  assign out_in_front = in_front_r;
  assign out_clipped  = clipped_r;

  // A point behind the camera always reads as (-1, -1) and is never clipped.
  a_behind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_front |->
      out_pixel_x == signed'(MINUS_ONE) && out_pixel_y == signed'(MINUS_ONE) && !out_clipped)
    else $error("behind-camera word malformed");

  // An empty output register never holds off the input.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // A waiting output word stays valid and unchanged until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_pixel_x) && $stable(out_pixel_y) &&
      $stable(out_in_front) && $stable(out_clipped))
    else $error("output word changed while stalled");

  // Reset empties the output.
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

/* tb/pinhole_point_projection_test.sv */
// Self-checking testbench for pinhole_point_projection: directed points, then
// random points under several matrix and depth settings, with random stalls.
// Depends on pph_pkg and the block's RTL only.
`timescale 1ns / 100ps

module pinhole_point_projection_test;
  import pph_pkg::*;

  localparam int FRAC = 16;
  localparam logic signed [31:0] ONE = 32'sd65536;
  localparam logic signed [31:0] NEG_ONE = -32'sd65536;
  localparam logic signed [31:0] MAX_Q = 32'sh7FFFFFFF;
  localparam logic signed [31:0] MIN_Q = 32'sh80000000;
  localparam logic [CFG_IDX_W-1:0] UNUSED_INDEX = 3'd7;
  localparam int PHASES = 9;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 45;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic        front;
    logic        clip;
  } pixel_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               typed;
    pixel_t             want;
  } point_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_point_x = '0;
  logic signed [31:0] in_point_y = '0;
  logic signed [31:0] in_point_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_pixel_x;
  logic signed [31:0] out_pixel_y;
  logic out_in_front;
  logic out_clipped;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  // Shadow of the block's registers, updated when a cfg word is taken.
  logic [63:0] matrix_regs [6];
  logic [30:0] depth_floor;

  pixel_t pending_pixels [$];
  bit failed = 1'b0;
  int idle_cycles = 0;

  pinhole_point_projection dut (.*);

  always #2 clk = ~clk;

  function automatic logic signed [65:0] row_depth_sum(int r, logic signed [31:0] x,
                                                       logic signed [31:0] y,
                                                       logic signed [31:0] z);
    logic signed [31:0] c [4];
    logic signed [65:0] s;
    c[0] = matrix_regs[2*r][31:0];
    c[1] = matrix_regs[2*r][63:32];
    c[2] = matrix_regs[2*r+1][31:0];
    c[3] = matrix_regs[2*r+1][63:32];
    s = c[0] * x + c[1] * y + c[2] * z + c[3] * ONE;
    return s >>> FRAC;
  endfunction

  // Truncating divide of num * 2^FRAC by den, saturating to 32 bits.
  function automatic logic [31:0] scaled_quotient(logic signed [65:0] num,
                                                  logic signed [65:0] den,
                                                  inout logic clip);
    logic neg;
    logic [65:0] mag;
    logic [127:0] q;
    logic [127:0] limit;
    neg = num < 0;
    mag = neg ? -num : num;
    if (mag == 0) return '0;
    limit = neg ? 128'h80000000 : 128'h7FFFFFFF;
    if (den <= 0) begin
      clip = 1'b1;
      return limit[31:0];
    end
    q = ({62'd0, mag} << FRAC) / {62'd0, den};
    if (q > limit) begin
      clip = 1'b1;
      q = limit;
    end
    return neg ? -q[31:0] : q[31:0];
  endfunction

  function automatic pixel_t project_point(logic signed [31:0] x, logic signed [31:0] y,
                                           logic signed [31:0] z);
    logic signed [65:0] u, v, w;
    pixel_t p;
    logic clip;
    u = row_depth_sum(0, x, y, z);
    v = row_depth_sum(1, x, y, z);
    w = row_depth_sum(2, x, y, z);
    clip = 1'b0;
    if (w < $signed({35'd0, depth_floor})) begin
      p = '{NEG_ONE, NEG_ONE, 1'b0, 1'b0};
    end else begin
      p.px = scaled_quotient(u, w, clip);
      p.py = scaled_quotient(v, w, clip);
      p.front = 1'b1;
      p.clip = clip;
    end
    return p;
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 8 * 65536)) - 4 * ONE;
      2: case ($urandom_range(0, 4))
           0: return MAX_Q;
           1: return MIN_Q;
           2: return 0;
           3: return 1;
           default: return -1;
         endcase
      default: return $signed($urandom_range(0, 512 * 65536)) - 256 * ONE;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_depth();
    if ($urandom_range(0, 3) == 0) return rand_coord();
    return $urandom_range(1, 64 * 65536);
  endfunction

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $signed($urandom_range(0, 8 * 65536)) - 4 * ONE;
      2: return 0;
      default: return ONE;
    endcase
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_MIN_DEPTH) depth_floor = data[30:0];
    else if (idx < 3'd6) matrix_regs[idx] = data;
  endtask

  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z, logic typed, pixel_t want);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_point_x <= x;
    in_point_y <= y;
    in_point_z <= z;
    do @(posedge clk); while (!in_ready);
    pending_pixels.insert(pending_pixels.size(), typed ? want : project_point(x, y, z));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  // Receiver side: random hold-off before each word, then ready until taken.
  initial begin
    int hold;
    @(posedge rst_n);
    forever begin
      hold = $urandom_range(0, 4);
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected output word: pixel_x %h pixel_y %h", out_pixel_x, out_pixel_y);
        failed = 1'b1;
      end else begin
        pixel_t e;
        e = pending_pixels.pop_front();
        if (out_pixel_x !== e.px) begin
          $error("pixel_x expected %h actual %h", e.px, out_pixel_x);
          failed = 1'b1;
        end
        if (out_pixel_y !== e.py) begin
          $error("pixel_y expected %h actual %h", e.py, out_pixel_y);
          failed = 1'b1;
        end
        if (out_in_front !== e.front) begin
          $error("in_front expected %b actual %b", e.front, out_in_front);
          failed = 1'b1;
        end
        if (out_clipped !== e.clip) begin
          $error("clipped expected %b actual %b", e.clip, out_clipped);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (rst_n)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    point_row_t rows [15];
    logic [63:0] fill;
    logic [31:0] d;
    pixel_t none;
    none = '0;
    matrix_regs = '{64'd65536, 64'd0, 64'h0001_0000_0000_0000, 64'd0, 64'd0, 64'd65536};
    depth_floor = 31'd66;
    rows = '{
      '{0, 0, ONE, 1'b1, '{0, 0, 1'b1, 1'b0}},
      '{ONE, 2 * ONE, ONE, 1'b1, '{ONE, 2 * ONE, 1'b1, 1'b0}},
      '{0, 0, 0, 1'b1, '{NEG_ONE, NEG_ONE, 1'b0, 1'b0}},
      '{5, 5, 65, 1'b1, '{NEG_ONE, NEG_ONE, 1'b0, 1'b0}},
      '{0, 0, 66, 1'b1, '{0, 0, 1'b1, 1'b0}},
      '{MAX_Q, MAX_Q, ONE, 1'b1, '{MAX_Q, MAX_Q, 1'b1, 1'b0}},
      '{MIN_Q, MIN_Q, ONE, 1'b1, '{MIN_Q, MIN_Q, 1'b1, 1'b0}},
      '{MAX_Q, MIN_Q, ONE / 2, 1'b1, '{MAX_Q, MIN_Q, 1'b1, 1'b1}},
      '{ONE, -ONE, MIN_Q, 1'b1, '{NEG_ONE, NEG_ONE, 1'b0, 1'b0}},
      '{3 * ONE, ONE, 2 * ONE, 1'b1, '{98304, 32768, 1'b1, 1'b0}},
      '{-3 * ONE, -ONE, 2 * ONE, 1'b1, '{-98304, -32768, 1'b1, 1'b0}},
      '{-ONE, ONE, MAX_Q, 1'b0, none},
      '{1, -1, 3 * ONE, 1'b0, none},
      '{32'shAAAAAAAA, 32'sh55555555, 32'sh7FFF0000, 1'b0, none},
      '{MIN_Q, MAX_Q, 67, 1'b0, none}
    };
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    foreach (rows[i]) send_point(rows[i].x, rows[i].y, rows[i].z, rows[i].typed, rows[i].want);
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        // The matrix is only rewritten with the pipeline empty.
        for (int r = 0; r < 6; r++) begin
          case (ph)
            1: fill = '1;
            2: fill = '0;
            3: fill = (r >= 4) ? 64'd0 : {rand_entry(), rand_entry()};
            default: fill = {rand_entry(), rand_entry()};
          endcase
          write_reg(pph_reg_t'(r), fill);
        end
        case (ph)
          1: d = 32'hFFFFFFFF;
          2, 3: d = 0;
          default: case ($urandom_range(0, 3))
                     0: d = 0;
                     1: d = 66;
                     2: d = $urandom_range(0, 4 * 65536);
                     default: d = 32'h7FFFFFFF;
                   endcase
        endcase
        write_reg(REG_MIN_DEPTH, {32'd0, d});
        if (ph == 1 || ph == 5) write_reg(UNUSED_INDEX, {$urandom, $urandom});
        cfg_valid <= 1'b0;
        @(posedge clk);
      end
      repeat (ITEMS_PER_PHASE) send_point(rand_coord(), rand_coord(), rand_depth(), 1'b0, none);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* sim.f */
rtl/pph_pkg.sv
rtl/pph_row_dot.sv
rtl/pph_div_cell.sv
rtl/pinhole_point_projection.sv
tb/pinhole_point_projection_test.sv
